// File: hdl/wavetable_loop_oscillator_core_macros.svh
// assertion macros for the wavetable loop oscillator core
// depends on nothing; included by the top level only
`ifndef WAVETABLE_LOOP_OSCILLATOR_CORE_MACROS_SVH
`define WAVETABLE_LOOP_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define WLO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define WLO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/wlo_pkg.sv
// shared constants for the wavetable loop oscillator: field widths,
// operation and register codes, reset values; depends on nothing
package wlo_pkg;

	localparam int DEF_MAX_FRAMES   = 1024;
	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_FRAC_BITS    = 16;
	localparam int DEF_SAMPLE_BITS  = 16;

	// word fields
	localparam int OP_W       = 2;
	localparam int ADDR_W     = 13;
	localparam int SAMPLE_W   = 16;
	localparam int DELTA_W    = 27;
	localparam int CH_IDX_W   = 3;

	// configuration registers
	localparam int TLEN_W      = 11;
	localparam int CHANS_W     = 4;
	localparam int INC_W       = 27;
	localparam int OFFSET_W    = 26;
	localparam int CFG_DATA_W  = 27;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS_IN_USE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INCREMENT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET    = 2'd3;

	localparam logic [TLEN_W-1:0]  RST_TABLE_LENGTH    = 11'd1024;
	localparam logic [CHANS_W-1:0] RST_CHANNELS_IN_USE = 4'd1;
	localparam logic [INC_W-1:0]   RST_PHASE_INCREMENT = 27'd65536;
	localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET   = 26'd0;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OP_W-1:0] OP_ADJUST = 2'd2;

endpackage

// File: hdl/wlo_in_if.sv
// input channel of the oscillator: valid/ready plus one input word
// depends on wlo_pkg
interface wlo_in_if;
	import wlo_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [OP_W-1:0]            operation;
	logic [ADDR_W-1:0]          table_address;
	logic signed [SAMPLE_W-1:0] write_sample;
	logic signed [DELTA_W-1:0]  phase_delta;

	modport source (output valid, operation, table_address, write_sample, phase_delta,
		input ready);
	modport sink (input valid, operation, table_address, write_sample, phase_delta,
		output ready);
endinterface

// File: hdl/wlo_out_if.sv
// output channel of the oscillator: valid/ready plus one result word
// depends on wlo_pkg
interface wlo_out_if;
	import wlo_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [CH_IDX_W-1:0]        channel_index;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       last_channel;

	modport source (output valid, channel_index, out_sample, last_channel, input ready);
	modport sink (input valid, channel_index, out_sample, last_channel, output ready);
endinterface

// File: hdl/wlo_table.sv
// sample table memory: one write port, two registered read ports
// depends on wlo_pkg for default sizes
module wlo_table #(
	parameter int SAMPLE_BITS = wlo_pkg::DEF_SAMPLE_BITS,
	parameter int DEPTH = wlo_pkg::DEF_MAX_FRAMES * wlo_pkg::DEF_MAX_CHANNELS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  logic [AW-1:0]          raddr_a,
	input  logic [AW-1:0]          raddr_b,
	output logic [SAMPLE_BITS-1:0] rdata_a,
	output logic [SAMPLE_BITS-1:0] rdata_b
);
	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_a_s1;
	logic [SAMPLE_BITS-1:0] rd_b_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= mem[raddr_a];
		rd_b_s1 <= mem[raddr_b];
	end

	assign rdata_a = rd_a_s1;
	assign rdata_b = rd_b_s1;
endmodule

// File: hdl/wlo_mod.sv
// phase reduction unit: signed fixed-point value modulo nf frames,
// one restoring compare/subtract per cycle; depends on wlo_pkg defaults
module wlo_mod #(
	parameter int FRAC_BITS = wlo_pkg::DEF_FRAC_BITS,
	parameter int NF_W = 11,
	parameter int XW = 29,
	localparam int RW = NF_W + FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [XW-1:0] x,
	input  logic [NF_W-1:0]      nf,
	output logic                 done,
	output logic [RW-1:0]        r
);
	localparam int IW   = XW - FRAC_BITS;
	localparam int KMAX = IW - 2;
	localparam int KW   = $clog2(IW);
	localparam int SW   = IW + NF_W;

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_RUN  = 2'd1;
	localparam logic [1:0] M_FIX  = 2'd2;

	logic [1:0]           st_q;
	logic                 done_q;
	logic [KW-1:0]        k_q;
	logic [IW-1:0]        int_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic                 neg_q;
	logic [RW-1:0]        r_q;

	logic [XW-1:0] mag;
	logic [SW-1:0] nf_shift;
	logic          ge_shift;
	logic          below_nf;
	logic [RW-1:0] rem;
	logic [RW-1:0] per;

	assign mag      = x[XW-1] ? XW'(-x) : XW'(x);
	assign nf_shift = SW'(nf) << k_q;
	assign ge_shift = SW'(int_q) >= nf_shift;
	assign below_nf = SW'(int_q) < SW'(nf);
	assign rem      = {int_q[NF_W-1:0], frac_q};
	assign per      = {nf, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (start) st_q <= M_RUN;
				end
				M_RUN: begin
					if (below_nf) st_q <= M_FIX;
				end
				M_FIX: begin
					st_q   <= M_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == M_IDLE && start) begin
			neg_q  <= x[XW-1];
			int_q  <= mag[XW-1:FRAC_BITS];
			frac_q <= mag[FRAC_BITS-1:0];
			k_q    <= KW'(KMAX);
		end else if (st_q == M_RUN && !below_nf) begin
			if (ge_shift) int_q <= int_q - nf_shift[IW-1:0];
			if (k_q != '0) k_q <= k_q - 1'b1;
		end
		if (st_q == M_FIX) begin
			// negative input: fold the magnitude's remainder back from the period
			r_q <= (neg_q && rem != '0) ? per - rem : rem;
		end
	end

	assign done = done_q;
	assign r    = r_q;
endmodule

// File: hdl/wavetable_loop_oscillator_core.sv
// wavetable loop oscillator top level. a write word is stored as it is accepted; an adjust
// word runs one reduction in the shared modulo unit; a tick runs two reductions there,
// then reads, multiplies and adds for each channel in use, one result word per channel.
// no new word is accepted until the current one is finished (ready only while idle);
// a stalled result word holds the sequencer.
// arst_n clears phase to zero and the registers to 1024, 1, 65536, 0; table undefined.
`include "wavetable_loop_oscillator_core_macros.svh"

module wavetable_loop_oscillator_core #(
	parameter int MAX_FRAMES   = wlo_pkg::DEF_MAX_FRAMES,
	parameter int MAX_CHANNELS = wlo_pkg::DEF_MAX_CHANNELS,
	parameter int FRAC_BITS    = wlo_pkg::DEF_FRAC_BITS,
	parameter int SAMPLE_BITS  = wlo_pkg::DEF_SAMPLE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wlo_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [wlo_pkg::CFG_DATA_W-1:0]   cfg_data,
	wlo_in_if.sink                           items,
	wlo_out_if.source                        results
);
	import wlo_pkg::*;

	// frames reachable through the 11-bit length register
	localparam int TLEN_MAX = (1 << TLEN_W) - 1;
	localparam int NF_MAX   = (MAX_FRAMES < TLEN_MAX) ? MAX_FRAMES : TLEN_MAX;
	localparam int NF_W     = $clog2(NF_MAX + 1);
	localparam int IXW      = (NF_MAX > 1) ? $clog2(NF_MAX) : 1;
	localparam int PW       = IXW + FRAC_BITS;
	localparam int CW       = $clog2(MAX_CHANNELS + 1);
	localparam int CHW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DEPTH    = MAX_FRAMES * MAX_CHANNELS;
	localparam int AW       = $clog2(DEPTH);
	localparam int RW       = NF_W + FRAC_BITS;
	// wide enough for phase plus the offset, the increment or a saturated delta
	localparam int XB       = (RW > INC_W) ? RW : INC_W;
	localparam int XW       = XB + 2;
	localparam int PRODW    = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int MULW     = IXW + CW;
	localparam int SMAX     = (1 << (SAMPLE_BITS - 1)) - 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POS  = 3'd1;
	localparam logic [2:0] S_INC  = 3'd2;
	localparam logic [2:0] S_BASE = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_ADD  = 3'd6;
	localparam logic [2:0] S_ADJ  = 3'd7;

	// configuration registers
	logic [TLEN_W-1:0]        tlen_q;
	logic [CHANS_W-1:0]       chans_q;
	logic signed [INC_W-1:0]  inc_q;
	logic [OFFSET_W-1:0]      offset_q;

	// sequencer and phase
	logic [2:0]              st_q;
	logic [PW-1:0]           phase_q;
	logic [PW-1:0]           pos_q;
	logic [CHW-1:0]          ch_q;
	logic [AW-1:0]           base_a_q;
	logic [AW-1:0]           base_b_q;
	logic [FRAC_BITS-1:0]    frac_q;

	// interpolation datapath
	logic signed [PRODW-1:0]       prod_s2;
	logic signed [SAMPLE_BITS-1:0] a_s2;

	// output register
	logic                       out_valid_q;
	logic [CH_IDX_W-1:0]        out_ch_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_last_q;

	logic [NF_W-1:0] nf;
	logic [CW-1:0]   nc;
	logic [RW-1:0]   period;
	logic            accept;

	always_comb begin
		// out-of-range lengths and channel counts clamp to the nearest legal value
		if (int'(tlen_q) < 2) nf = NF_W'(2);
		else if (int'(tlen_q) > NF_MAX) nf = NF_W'(NF_MAX);
		else nf = NF_W'(tlen_q);
		if (chans_q == '0) nc = CW'(1);
		else if (int'(chans_q) > MAX_CHANNELS) nc = CW'(MAX_CHANNELS);
		else nc = CW'(chans_q);
	end

	assign period = {nf, {FRAC_BITS{1'b0}}};
	assign accept = items.valid && items.ready;
	assign items.ready = (st_q == S_IDLE);

	// adjust delta, magnitude held below one period
	logic signed [XW-1:0] d_ext, lim, d_sat;
	always_comb begin
		d_ext = XW'(items.phase_delta);
		lim   = XW'(period) - XW'(1);
		if (d_ext > lim) d_sat = lim;
		else if (d_ext < -lim) d_sat = -lim;
		else d_sat = d_ext;
	end

	// modulo unit operand: phase plus offset, increment or delta
	logic signed [XW-1:0] phase_ext, addend, mod_x;
	logic                 mod_start;
	logic                 mod_done;
	logic [RW-1:0]        mod_r;

	always_comb begin
		phase_ext = XW'(phase_q);
		priority if (st_q == S_POS) addend = XW'(inc_q);
		else if (items.operation == OP_ADJUST) addend = d_sat;
		else addend = XW'(offset_q);
		mod_x = phase_ext + addend;
		mod_start = (accept && (items.operation == OP_TICK || items.operation == OP_ADJUST))
			|| (st_q == S_POS && mod_done);
	end

	wlo_mod #(
		.FRAC_BITS (FRAC_BITS),
		.NF_W      (NF_W),
		.XW        (XW)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.x      (mod_x),
		.nf     (nf),
		.done   (mod_done),
		.r      (mod_r)
	);

	// table write path: out-of-range addresses dropped, samples saturated
	logic                   tbl_we;
	logic [SAMPLE_BITS-1:0] wr_sample;
	always_comb begin
		tbl_we = accept && items.operation == OP_WRITE && int'(items.table_address) < DEPTH;
		if (int'(items.write_sample) > SMAX) wr_sample = SAMPLE_BITS'(SMAX);
		else if (int'(items.write_sample) < -SMAX - 1) wr_sample = SAMPLE_BITS'(-SMAX - 1);
		else wr_sample = SAMPLE_BITS'(items.write_sample);
	end

	logic [AW-1:0]          raddr_a, raddr_b;
	logic [SAMPLE_BITS-1:0] rdata_a, rdata_b;
	assign raddr_a = base_a_q + AW'(ch_q);
	assign raddr_b = base_b_q + AW'(ch_q);

	wlo_table #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.DEPTH       (DEPTH)
	) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (AW'(items.table_address)),
		.wdata   (wr_sample),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// frame index, fraction and the next frame with wrap to frame 0
	logic [IXW-1:0] idx, nxt;
	always_comb begin
		idx = pos_q[PW-1:FRAC_BITS];
		if (int'(idx) + 1 >= int'(nf)) nxt = '0;
		else nxt = idx + 1'b1;
	end

	// interpolation: a + floor((b-a)*frac/2^F + 1/2)
	logic signed [SAMPLE_BITS:0]     diff;
	logic signed [FRAC_BITS:0]       frac_sx;
	logic signed [PRODW-1:0]         diff_w, frac_w;
	logic signed [PRODW-1:0]         t_rnd, y_w;
	logic signed [SAMPLE_BITS-1:0]   y_sb;
	logic                            is_last;
	logic                            out_load;

	assign diff    = {rdata_b[SAMPLE_BITS-1], rdata_b} - {rdata_a[SAMPLE_BITS-1], rdata_a};
	assign frac_sx = {1'b0, frac_q};
	assign diff_w  = PRODW'(diff);
	assign frac_w  = PRODW'(frac_sx);
	assign t_rnd   = prod_s2 + (PRODW'(1) <<< (FRAC_BITS - 1));
	assign y_w     = PRODW'(a_s2) + (t_rnd >>> FRAC_BITS);
	assign y_sb    = y_w[SAMPLE_BITS-1:0];
	assign is_last = (int'(ch_q) + 1 == int'(nc));
	assign out_load = (st_q == S_ADD) && (!out_valid_q || results.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q   <= RST_TABLE_LENGTH;
			chans_q  <= RST_CHANNELS_IN_USE;
			inc_q    <= RST_PHASE_INCREMENT;
			offset_q <= RST_PHASE_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TABLE_LENGTH:    tlen_q   <= cfg_data[TLEN_W-1:0];
				REG_CHANNELS_IN_USE: chans_q  <= cfg_data[CHANS_W-1:0];
				REG_PHASE_INCREMENT: inc_q    <= cfg_data[INC_W-1:0];
				REG_PHASE_OFFSET:    offset_q <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: tick = lookup position, advance phase, then one channel at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			phase_q <= '0;
			ch_q    <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						if (items.operation == OP_TICK) st_q <= S_POS;
						else if (items.operation == OP_ADJUST) st_q <= S_ADJ;
					end
				end
				S_POS: begin
					// next reduction starts at once: phase plus increment
					if (mod_done) st_q <= S_INC;
				end
				S_INC: begin
					if (mod_done) begin
						phase_q <= mod_r[PW-1:0];
						st_q    <= S_BASE;
					end
				end
				S_BASE: begin
					ch_q <= '0;
					st_q <= S_RD;
				end
				S_RD:  st_q <= S_MUL;
				S_MUL: st_q <= S_ADD;
				S_ADD: begin
					if (out_load) begin
						if (is_last) st_q <= S_IDLE;
						else begin
							ch_q <= ch_q + 1'b1;
							st_q <= S_RD;
						end
					end
				end
				S_ADJ: begin
					if (mod_done) begin
						phase_q <= mod_r[PW-1:0];
						st_q    <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (st_q == S_POS && mod_done) pos_q <= mod_r[PW-1:0];
		if (st_q == S_BASE) begin
			base_a_q <= AW'(MULW'(idx) * MULW'(nc));
			base_b_q <= AW'(MULW'(nxt) * MULW'(nc));
			frac_q   <= pos_q[FRAC_BITS-1:0];
		end
		if (st_q == S_MUL) begin
			prod_s2 <= diff_w * frac_w;
			a_s2    <= rdata_a;
		end
		if (out_load) begin
			out_ch_q     <= CH_IDX_W'(ch_q);
			out_sample_q <= SAMPLE_W'(y_sb);
			out_last_q   <= is_last;
		end
	end

	// output register decouples the sequencer from the result sink
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.channel_index = out_ch_q;
	assign results.out_sample    = out_sample_q;
	assign results.last_channel  = out_last_q;

	// the modulo unit only finishes while the sequencer waits for it
	`WLO_ASSERT_NOW(a_mod_done_waited, clk, arst_n, mod_done, (st_q == S_POS || st_q == S_INC || st_q == S_ADJ), "modulo result with no waiting step")
	// a reduced phase always lies inside one period
	`WLO_ASSERT_NOW(a_mod_in_period, clk, arst_n, mod_done, (mod_r < period), "reduced phase outside the period")
	// a new word never overwrites one still waiting at the output
	`WLO_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_load, (!results.valid || results.ready), "result word overwritten")
	// the final channel shows up flagged on the next cycle
	`WLO_ASSERT_NEXT(a_last_flagged, clk, arst_n, (out_load && is_last), (results.valid && results.last_channel), "last channel word not flagged")
endmodule
